// File: src/pwc_pkg.sv
`default_nettype none

package pwc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FIFO_DEPTH = 2;

  localparam logic [15:0] TICK_LEN_RESET = 16'd256;
  localparam logic [23:0] DUTY_SCALE = 24'd100;
  localparam logic [7:0] DUTY_MAX = 8'd255;

  typedef enum logic [1:0] {
    PH_WAIT_RISE = 2'd0,
    PH_PERIOD    = 2'd1,
    PH_HIGH      = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'd0,
    B_MUL  = 3'd1,
    B_CHK  = 3'd2,
    B_DIV  = 3'd3,
    B_OUT  = 3'd4
  } back_state_t;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] high;
  } capture_t;

endpackage

`default_nettype wire

// File: src/pwc_front.sv
`default_nettype none

module pwc_front
  import pwc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     pulse_level,
  input  wire logic     full,
  output logic          push,
  output capture_t      push_data
);

  phase_t phase, phase_next;
  logic [COUNT_WIDTH-1:0] counter, counter_next;
  logic [COUNT_WIDTH-1:0] cap_period, cap_period_next;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic prev_level;
  logic accept, rising, falling;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign rising   = !prev_level && pulse_level;
  assign falling  = prev_level && !pulse_level;
  assign cnt_inc  = counter + COUNT_WIDTH'(1);

  always_comb begin
    phase_next      = phase;
    counter_next    = counter;
    cap_period_next = cap_period;
    if (accept) begin
      counter_next = cnt_inc;
      case (phase)
        PH_PERIOD: begin
          if (rising) begin
            cap_period_next = cnt_inc;
            counter_next    = '0;
            phase_next      = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (falling) begin
            phase_next = PH_WAIT_RISE;
          end
        end
        default: begin
          if (rising) begin
            counter_next = '0;
            phase_next   = PH_PERIOD;
          end
        end
      endcase
    end
  end

  always_comb begin
    push             = accept && (phase == PH_HIGH) && falling;
    push_data.period = 16'(cap_period);
    push_data.high   = 16'(cnt_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT_RISE;
      counter    <= '0;
      prev_level <= 1'b0;
      cap_period <= '0;
    end else begin
      phase      <= phase_next;
      counter    <= counter_next;
      cap_period <= cap_period_next;
      if (accept) begin
        prev_level <= pulse_level;
      end
    end
  end

`ifndef SYNTHESIS
  a_push_phase: assert property (@(posedge clk) disable iff (rst)
    push |-> (phase == PH_HIGH) && prev_level && !pulse_level)
    else $error("capture pushed outside high phase");
`endif

endmodule

`default_nettype wire

// File: src/pwc_fifo.sv
`default_nettype none

module pwc_fifo
  import pwc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire capture_t push_data,
  input  wire logic     pop,
  output capture_t      pop_data,
  output logic          full,
  output logic          empty
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  capture_t mem [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;

  assign full     = (count == (AW+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: src/pwc_back.sv
`default_nettype none

module pwc_back
  import pwc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] tick_length_q8,
  input  wire logic        empty,
  input  wire capture_t    pop_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      period_ticks,
  output logic [15:0]      high_ticks,
  output logic [23:0]      period_duration,
  output logic [23:0]      high_time,
  output logic [7:0]       duty_percent
);

  back_state_t state, state_next;
  logic [15:0] per, hi;
  logic [23:0] ptime, htime;
  logic [23:0] num, rem, dvs;
  logic [7:0]  quo, duty;
  logic [2:0]  step;
  logic        sat, qbit;
  logic [31:0] pprod, hprod;

  assign sat   = (num >= {per, 8'b0});
  assign qbit  = (rem >= dvs);
  assign pprod = 32'(per) * 32'(tick_length_q8);
  assign hprod = 32'(hi) * 32'(tick_length_q8);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!empty) state_next = B_MUL;
      B_MUL:  state_next = B_CHK;
      B_CHK: begin
        if ((per == 16'd0) || sat) state_next = B_OUT;
        else state_next = B_DIV;
      end
      B_DIV:  if (step == 3'd0) state_next = B_OUT;
      B_OUT:  if (out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == B_IDLE) && !empty;
    out_valid = (state == B_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          per <= pop_data.period;
          hi  <= pop_data.high;
        end
      end
      B_MUL: begin
        ptime <= pprod[31:8];
        htime <= hprod[31:8];
        num   <= 24'(hi) * DUTY_SCALE;
      end
      B_CHK: begin
        rem  <= num;
        dvs  <= {1'b0, per, 7'b0};
        step <= 3'd7;
        quo  <= '0;
        if (per == 16'd0) duty <= '0;
        else if (sat) duty <= DUTY_MAX;
      end
      B_DIV: begin
        if (qbit) rem <= rem - dvs;
        quo  <= {quo[6:0], qbit};
        duty <= {quo[6:0], qbit};
        dvs  <= dvs >> 1;
        step <= step - 3'd1;
      end
      default: begin
      end
    endcase
  end

  assign period_ticks    = per;
  assign high_ticks      = hi;
  assign period_duration = ptime;
  assign high_time       = htime;
  assign duty_percent    = duty;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (per != 16'd0) && (rem < {per, 8'b0}))
    else $error("divide step with bad operands");
`endif

endmodule

`default_nettype wire

// File: src/pwm_period_duty_capture_top.sv
// A capture leaves the front in the cycle of the falling edge; the back end then steps through
// B_MUL and B_CHK to B_OUT when duty saturates or the period is zero, else through B_DIV first.
// Throughput: one pulse sample per cycle while the two-entry queue has room, in_ready low when full;
// the back end takes one capture at a time and pops the next only after out_ready takes its result.
// Reset (rst, synchronous): phase, counter, edge history, queue and back-end state clear;
// tick length returns to 256 (1.0 in Q8.8).
`default_nettype none

module pwm_period_duty_capture_top
  import pwc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        pulse_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      period_ticks,
  output logic [15:0]      high_ticks,
  output logic [23:0]      period_duration,
  output logic [23:0]      high_time,
  output logic [7:0]       duty_percent
);

  logic [15:0] tick_length_q8;
  logic        push, pop, full, empty;
  capture_t    push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_length_q8 <= TICK_LEN_RESET;
    end else if (cfg_we) begin
      tick_length_q8 <= cfg_wdata;
    end
  end

  pwc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pulse_level(pulse_level),
    .full       (full),
    .push       (push),
    .push_data  (push_data)
  );

  pwc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (full),
    .empty    (empty)
  );

  pwc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .tick_length_q8 (tick_length_q8),
    .empty          (empty),
    .pop_data       (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .period_ticks   (period_ticks),
    .high_ticks     (high_ticks),
    .period_duration(period_duration),
    .high_time      (high_time),
    .duty_percent   (duty_percent)
  );

endmodule

`default_nettype wire
